// File: sv/pbam_pkg.sv
// Package for the pixel background average model: shared constants, codes and
// payload types. No dependencies.
package pbam_pkg;

    localparam int unsigned PIXELS     = 131072;
    localparam int unsigned PIX_W      = $clog2(PIXELS);
    localparam int unsigned MAX_FRAMES = 1023;
    localparam int unsigned FL_W       = $clog2(MAX_FRAMES + 1);
    localparam int unsigned SUM_W      = $clog2(255 * MAX_FRAMES + 1);
    localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(255 * MAX_FRAMES);
    localparam int unsigned QDEPTH     = 4;
    localparam int unsigned QPTR_W     = $clog2(QDEPTH);
    localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1) + 1;

    localparam logic [7:0] MASK_FG    = 8'hFF;
    localparam logic [7:0] MASK_BG    = 8'h00;
    localparam logic [7:0] HIGH_RESET = 8'd112;
    localparam logic [7:0] LOW_RESET  = 8'd96;

    typedef enum logic [0:0] {
        CFG_HIGH_SCALE = 1'b0,
        CFG_LOW_SCALE  = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        OP_LEARN    = 1'b0,
        OP_CLASSIFY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        K_LEARN_FIRST,
        K_LEARN_ACC,
        K_CLASSIFY,
        K_CLASSIFY_FIXED
    } kind_t;

    typedef struct packed {
        logic        opcode;
        logic [16:0] pixel_index;
        logic [7:0]  chan_a;
        logic [7:0]  chan_b;
        logic [7:0]  chan_c;
        logic        end_of_frame;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  foreground_mask;
        logic [16:0] pixel_index_out;
        logic        model_empty;
    } result_t;

    typedef struct packed {
        kind_t                 kind;
        logic [PIX_W-1:0]      idx;
        logic [2:0][7:0]       ch;
        logic [FL_W-1:0]       n;
        logic                  empty;
    } work_t;

    typedef struct packed {
        logic [2:0][SUM_W-1:0] cs;
        logic [2:0][SUM_W-1:0] ds;
    } sums_t;

endpackage

// File: sv/pbam_fifo.sv
// Short work queue between the front and the back of the block.
// Depends on pbam_pkg for the work item type and depth.
module pbam_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  pbam_pkg::work_t wr_data,
    output logic           q_full,
    input  logic           rd_en,
    output pbam_pkg::work_t rd_data,
    output logic           q_empty
);
    import pbam_pkg::*;

    work_t               mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic [QCNT_W-1:0]   cnt_next;

    assign q_full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: sv/pbam_front.sv
// Front end: accepts items, tracks the frame count and sorts each item into
// a work kind for the back end. Depends on pbam_pkg.
module pbam_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pbam_pkg::in_item_t item,
    output logic              full,
    input  logic              q_full,
    input  logic              clearing,
    output logic              q_wr,
    output pbam_pkg::work_t    q_data
);
    import pbam_pkg::*;

    logic [FL_W-1:0] frames_reg;
    logic [FL_W-1:0] frames_next;
    logic            first_seen_reg;
    logic            first_seen_next;
    logic            accept;
    logic            in_range;
    logic            model_full;

    assign full       = q_full || clearing;
    assign accept     = push && !full;
    assign in_range   = (32'(item.pixel_index) < PIXELS);
    assign model_full = (32'(frames_reg) >= MAX_FRAMES);

    always_comb
    begin
        frames_next     = frames_reg;
        first_seen_next = first_seen_reg;
        q_wr            = 1'b0;
        q_data.idx      = PIX_W'(item.pixel_index);
        q_data.ch       = {item.chan_c, item.chan_b, item.chan_a};
        q_data.n        = frames_reg;
        q_data.empty    = (frames_reg == '0);
        q_data.kind     = K_CLASSIFY;
        if (accept)
        begin
            if (op_t'(item.opcode) == OP_LEARN)
            begin
                if (!model_full)
                begin
                    q_wr        = in_range;
                    q_data.kind = first_seen_reg ? K_LEARN_ACC : K_LEARN_FIRST;
                    if (item.end_of_frame)
                    begin
                        if (first_seen_reg)
                        begin
                            frames_next = frames_reg + 1'b1;
                        end
                        else
                        begin
                            first_seen_next = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                q_wr = 1'b1;
                if ((frames_reg == '0) || !in_range)
                begin
                    q_data.kind = K_CLASSIFY_FIXED;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg     <= '0;
            first_seen_reg <= 1'b0;
        end
        else
        begin
            frames_reg     <= frames_next;
            first_seen_reg <= first_seen_next;
        end
    end

endmodule

// File: sv/pbam_back.sv
// Back end: per-pixel memories with read-modify-write and forwarding, the
// band test pipeline, configuration registers and the result queue.
// Depends on pbam_pkg.
module pbam_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [0:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              q_empty,
    input  pbam_pkg::work_t    q_data,
    output logic              q_rd,
    output logic              clearing,
    output logic              empty,
    input  logic              pop,
    output pbam_pkg::result_t  result
);
    import pbam_pkg::*;

    // Configuration
    logic [7:0] high_reg;
    logic [7:0] low_reg;

    // Memories
    logic [2:0][7:0] prev_mem [PIXELS];
    sums_t           sum_mem  [PIXELS];
    logic [2:0][7:0] prev_rd_reg;
    sums_t           sum_rd_reg;

    // Clearing pass
    logic             clr_active_reg;
    logic [PIX_W-1:0] clr_addr_reg;

    // Stage 1
    logic  s1_v_reg;
    work_t s1_reg;
    logic [2:0][7:0] prev_f;
    sums_t           sums_f;
    sums_t           sums_new;
    logic            s1_learn;
    logic            s1_acc;
    logic            s1_cls;
    logic [2:0][21:0] lhs_c;
    logic [2:0][21:0] base_c;
    logic [2:0][26:0] lo_c;
    logic [2:0][26:0] hi_c;

    // Forwarding of the write made at the previous edge
    logic             fwd_prev_v_reg;
    logic             fwd_sum_v_reg;
    logic [PIX_W-1:0] fwd_idx_reg;
    logic [2:0][7:0]  fwd_prev_reg;
    sums_t            fwd_sums_reg;

    // Stage 2
    logic             s2_v_reg;
    logic             s2_fixed_reg;
    logic             s2_empty_reg;
    logic [PIX_W-1:0] s2_idx_reg;
    logic [2:0][21:0] s2_lhs_reg;
    logic [2:0][21:0] s2_base_reg;
    logic [2:0][26:0] s2_lo_reg;
    logic [2:0][26:0] s2_hi_reg;
    result_t          s2_res;

    // Result queue
    result_t           oq_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] oq_wr_reg;
    logic [QPTR_W-1:0] oq_rd_reg;
    logic [QCNT_W-1:0] oq_cnt_reg;
    logic [QCNT_W-1:0] oq_cnt_next;
    logic [QCNT_W-1:0] credit_use;
    logic              oq_pop;

    assign clearing = clr_active_reg;

    // Items are only taken when the result queue has room for everything in flight.
    assign credit_use = oq_cnt_reg + QCNT_W'(s1_v_reg) + QCNT_W'(s2_v_reg);
    assign q_rd       = !q_empty && !clr_active_reg && (credit_use < QCNT_W'(QDEPTH));

    assign s1_learn = s1_v_reg && ((s1_reg.kind == K_LEARN_FIRST) ||
                                   (s1_reg.kind == K_LEARN_ACC));
    assign s1_acc   = s1_v_reg && (s1_reg.kind == K_LEARN_ACC);
    assign s1_cls   = s1_v_reg && ((s1_reg.kind == K_CLASSIFY) ||
                                   (s1_reg.kind == K_CLASSIFY_FIXED));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg <= HIGH_RESET;
            low_reg  <= LOW_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_HIGH_SCALE: high_reg <= cfg_data;
                CFG_LOW_SCALE:  low_reg  <= cfg_data;
                default:        high_reg <= high_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == PIX_W'(PIXELS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_learn)
        begin
            prev_mem[s1_reg.idx] <= s1_reg.ch;
        end
        if (q_rd)
        begin
            prev_rd_reg <= prev_mem[q_data.idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            sum_mem[clr_addr_reg] <= '0;
        end
        else if (s1_acc)
        begin
            sum_mem[s1_reg.idx] <= sums_new;
        end
        if (q_rd)
        begin
            sum_rd_reg <= sum_mem[q_data.idx];
        end
    end

    always_comb
    begin
        logic [7:0]       x;
        logic [7:0]       p;
        logic [7:0]       ad;
        logic [SUM_W:0]   cs_sum;
        logic [SUM_W:0]   ds_sum;
        logic [17:0]      xn;
        logic [SUM_W:0]   spread;
        prev_f = (fwd_prev_v_reg && (fwd_idx_reg == s1_reg.idx)) ? fwd_prev_reg
                                                                  : prev_rd_reg;
        sums_f = (fwd_sum_v_reg && (fwd_idx_reg == s1_reg.idx)) ? fwd_sums_reg
                                                                 : sum_rd_reg;
        for (int k = 0; k < 3; k++)
        begin
            x  = s1_reg.ch[k];
            p  = prev_f[k];
            ad = (x > p) ? (x - p) : (p - x);
            cs_sum = (SUM_W+1)'(sums_f.cs[k]) + (SUM_W+1)'(x);
            ds_sum = (SUM_W+1)'(sums_f.ds[k]) + (SUM_W+1)'(ad);
            sums_new.cs[k] = (cs_sum > (SUM_W+1)'(SUM_LIMIT)) ? SUM_LIMIT
                                                               : cs_sum[SUM_W-1:0];
            sums_new.ds[k] = (ds_sum > (SUM_W+1)'(SUM_LIMIT)) ? SUM_LIMIT
                                                               : ds_sum[SUM_W-1:0];
            xn        = 18'(x) * 18'(s1_reg.n);
            lhs_c[k]  = {xn, 4'b0000};
            base_c[k] = {sums_f.cs[k], 4'b0000};
            spread    = (SUM_W+1)'(sums_f.ds[k]) + (SUM_W+1)'(s1_reg.n);
            lo_c[k]   = 27'(low_reg) * 27'(spread);
            hi_c[k]   = 27'(high_reg) * 27'(spread);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg       <= 1'b0;
            s2_v_reg       <= 1'b0;
            fwd_prev_v_reg <= 1'b0;
            fwd_sum_v_reg  <= 1'b0;
        end
        else
        begin
            s1_v_reg       <= q_rd;
            s2_v_reg       <= s1_cls;
            fwd_prev_v_reg <= s1_learn;
            fwd_sum_v_reg  <= s1_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            s1_reg <= q_data;
        end
        fwd_idx_reg   <= s1_reg.idx;
        fwd_prev_reg  <= s1_reg.ch;
        fwd_sums_reg  <= sums_new;
        s2_fixed_reg  <= (s1_reg.kind == K_CLASSIFY_FIXED);
        s2_empty_reg  <= s1_reg.empty;
        s2_idx_reg    <= s1_reg.idx;
        s2_lhs_reg    <= lhs_c;
        s2_base_reg   <= base_c;
        s2_lo_reg     <= lo_c;
        s2_hi_reg     <= hi_c;
    end

    // The lower bound is tested as lhs + low product >= base to stay unsigned.
    always_comb
    begin
        logic any_in;
        any_in = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if (((28'(s2_lhs_reg[k]) + 28'(s2_lo_reg[k])) >= 28'(s2_base_reg[k])) &&
                (28'(s2_lhs_reg[k]) < (28'(s2_base_reg[k]) + 28'(s2_hi_reg[k]))))
            begin
                any_in = 1'b1;
            end
        end
        s2_res.foreground_mask = (!s2_fixed_reg && any_in) ? MASK_BG : MASK_FG;
        s2_res.pixel_index_out = 17'(s2_idx_reg);
        s2_res.model_empty     = s2_empty_reg;
    end

    assign oq_pop = pop && (oq_cnt_reg != '0);
    assign empty  = (oq_cnt_reg == '0);
    assign result = oq_mem_reg[oq_rd_reg];

    always_comb
    begin
        oq_cnt_next = oq_cnt_reg;
        if (s2_v_reg && !oq_pop)
        begin
            oq_cnt_next = oq_cnt_reg + 1'b1;
        end
        else if (!s2_v_reg && oq_pop)
        begin
            oq_cnt_next = oq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (s2_v_reg)
            begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (oq_pop)
            begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_v_reg)
        begin
            oq_mem_reg[oq_wr_reg] <= s2_res;
        end
    end

endmodule

// File: sv/pixel_background_average_model_core.sv
// Top level of the pixel background average model.
// Depends on pbam_pkg, pbam_front, pbam_fifo and pbam_back.
//
//  Port group        | Direction | Handshake       | Payload
//  ------------------+-----------+-----------------+------------------------
//  push/full/item    | in        | push && !full   | in_item_t
//  empty/pop/result  | out       | pop && !empty   | result_t
//  cfg_*             | in        | valid && ready  | cfg_index, cfg_data
//
// One item per clock is sustained while full stays low; a classify result passes
// from its transaction through the work queue, the registered memory read, the
// band test stage and the result queue.
// After reset the sum memory is cleared one row per cycle through all 131072 rows,
// during which full stays high. Configuration is taken at any time.
// A stalled result side fills the four-entry queues and then raises full.
module pixel_background_average_model_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  pbam_pkg::in_item_t item,
    output logic              empty,
    input  logic              pop,
    output pbam_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [7:0]        cfg_data
);
    import pbam_pkg::*;

    logic  q_wr;
    logic  q_rd;
    logic  q_full;
    logic  q_empty;
    logic  clearing;
    work_t q_wr_data;
    work_t q_rd_data;

    assign cfg_ready = 1'b1;

    pbam_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .q_full   (q_full),
        .clearing (clearing),
        .q_wr     (q_wr),
        .q_data   (q_wr_data)
    );

    pbam_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rd_data),
        .q_empty (q_empty)
    );

    pbam_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_data    (q_rd_data),
        .q_rd      (q_rd),
        .clearing  (clearing),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// File: sv/pbam_checker.sv
// Port-level checks for the pixel background average model.
// Depends on pbam_pkg; bound to the top level below.
module pbam_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              push,
    input logic              full,
    input pbam_pkg::in_item_t item,
    input logic              empty,
    input logic              pop,
    input pbam_pkg::result_t  result,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [0:0]        cfg_index,
    input logic [7:0]        cfg_data
);
    import pbam_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("waiting result vanished");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(result))
        else $error("waiting result changed");

    a_mask_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.foreground_mask == MASK_FG) ||
                   (result.foreground_mask == MASK_BG))
        else $error("mask is neither background nor foreground");

    a_empty_fg: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.model_empty |-> result.foreground_mask == MASK_FG)
        else $error("empty model gave background");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> empty)
        else $error("result present right after reset");

endmodule

bind pixel_background_average_model_core pbam_checker u_pbam_checker (.*);
